@@ hw/rtl/dmbs_pkg.sv @@
package dmbs_pkg;

   localparam int POS_W     = 8;
   localparam int WIDTH_W   = 16;
   localparam int HEIGHT_W  = 16;
   localparam int REFRESH_W = 10;
   localparam int TYPE_W    = 8;
   localparam int AREA_W    = 32;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED_TYPE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXACT_SIZE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PREF_REFRESH  = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic [TYPE_W-1:0]    required_type_bits;
      logic [WIDTH_W-1:0]   target_width;
      logic [HEIGHT_W-1:0]  target_height;
      logic                 exact_size;
      logic [REFRESH_W-1:0] preferred_refresh;
   } cfg_type;

   // one classified timing on its way from front to back
   typedef struct packed {
      logic                 pass;
      logic                 pref;
      logic                 last;
      logic [POS_W-1:0]     pos;
      logic [WIDTH_W-1:0]   width;
      logic [HEIGHT_W-1:0]  height;
      logic [REFRESH_W-1:0] refresh;
   } entry_type;

endpackage

@@ hw/rtl/display_mode_best_select_unit.sv @@
// A list's last item passes the queue and stage 1; its result is then registered.
// Throughput: one item per cycle; the front stalls only when the 4-entry queue is full,
// which happens while a finished result waits in the output register.
// Reset (synchronous, active high) zeroes the configuration, empties the queue and clears
// the scan state and output valid; data registers are not reset, no clearing pass is needed.
module display_mode_best_select_unit #(
   parameter int MAX_TIMINGS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dmbs_pkg::TYPE_W-1:0]          req_timing_type,
   input  logic [dmbs_pkg::WIDTH_W-1:0]         req_active_width,
   input  logic [dmbs_pkg::HEIGHT_W-1:0]        req_active_height,
   input  logic [dmbs_pkg::REFRESH_W-1:0]       req_refresh_hz,
   input  logic                                 req_interlaced,
   input  logic                                 req_double_scan,
   input  logic                                 req_last_entry,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [dmbs_pkg::POS_W-1:0]           rsp_best_position,
   output logic [dmbs_pkg::WIDTH_W-1:0]         rsp_best_width,
   output logic [dmbs_pkg::HEIGHT_W-1:0]        rsp_best_height,
   output logic [dmbs_pkg::REFRESH_W-1:0]       rsp_best_refresh_hz,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dmbs_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dmbs_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dmbs_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   dmbs_pkg::cfg_type   cfg;
   dmbs_pkg::entry_type front_entry;
   dmbs_pkg::entry_type head_entry;
   logic                q_full;
   logic                q_not_empty;
   logic                q_pop;
   logic                accept;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   dmbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dmbs_front #(
      .MAX_TIMINGS (MAX_TIMINGS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .timing_type   (req_timing_type),
      .active_width  (req_active_width),
      .active_height (req_active_height),
      .refresh_hz    (req_refresh_hz),
      .interlaced    (req_interlaced),
      .double_scan   (req_double_scan),
      .last_entry    (req_last_entry),
      .entry         (front_entry)
   );

   dmbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   dmbs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (q_not_empty),
      .head_entry          (head_entry),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_best_position   (rsp_best_position),
      .rsp_best_width      (rsp_best_width),
      .rsp_best_height     (rsp_best_height),
      .rsp_best_refresh_hz (rsp_best_refresh_hz)
   );

endmodule

@@ hw/rtl/dmbs_csr.sv @@
module dmbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dmbs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dmbs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dmbs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output dmbs_pkg::cfg_type                   cfg
);

   dmbs_pkg::cfg_type cfg_ff;
   dmbs_pkg::cfg_type cfg_in;
   logic [dmbs_pkg::CSR_IDX_W-1:0] idx;
   logic                           wr_en;

   assign idx        = csr_paddr[dmbs_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            dmbs_pkg::CSR_REQUIRED_TYPE:
               cfg_in.required_type_bits = csr_pwdata[dmbs_pkg::TYPE_W-1:0];
            dmbs_pkg::CSR_TARGET_WIDTH:
               cfg_in.target_width = csr_pwdata[dmbs_pkg::WIDTH_W-1:0];
            dmbs_pkg::CSR_TARGET_HEIGHT:
               cfg_in.target_height = csr_pwdata[dmbs_pkg::HEIGHT_W-1:0];
            dmbs_pkg::CSR_EXACT_SIZE:
               cfg_in.exact_size = csr_pwdata[0];
            dmbs_pkg::CSR_PREF_REFRESH:
               cfg_in.preferred_refresh = csr_pwdata[dmbs_pkg::REFRESH_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         dmbs_pkg::CSR_REQUIRED_TYPE:
            csr_prdata = {24'd0, cfg_ff.required_type_bits};
         dmbs_pkg::CSR_TARGET_WIDTH:
            csr_prdata = {16'd0, cfg_ff.target_width};
         dmbs_pkg::CSR_TARGET_HEIGHT:
            csr_prdata = {16'd0, cfg_ff.target_height};
         dmbs_pkg::CSR_EXACT_SIZE:
            csr_prdata = {31'd0, cfg_ff.exact_size};
         dmbs_pkg::CSR_PREF_REFRESH:
            csr_prdata = {22'd0, cfg_ff.preferred_refresh};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/dmbs_front.sv @@
module dmbs_front #(
   parameter int MAX_TIMINGS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dmbs_pkg::cfg_type                    cfg,
   input  logic                                 accept,
   input  logic [dmbs_pkg::TYPE_W-1:0]          timing_type,
   input  logic [dmbs_pkg::WIDTH_W-1:0]         active_width,
   input  logic [dmbs_pkg::HEIGHT_W-1:0]        active_height,
   input  logic [dmbs_pkg::REFRESH_W-1:0]       refresh_hz,
   input  logic                                 interlaced,
   input  logic                                 double_scan,
   input  logic                                 last_entry,
   output dmbs_pkg::entry_type                  entry
);

   localparam int CapInt = (MAX_TIMINGS - 1 < 255) ? MAX_TIMINGS - 1 : 255;
   localparam logic [dmbs_pkg::POS_W-1:0] PosCap = dmbs_pkg::POS_W'(CapInt);

   logic [dmbs_pkg::POS_W-1:0] pos_ff;
   logic [dmbs_pkg::POS_W-1:0] pos_in;
   logic                       type_ok;
   logic                       size_ok;

   assign type_ok = (timing_type & cfg.required_type_bits) == cfg.required_type_bits;

   always_comb begin
      if (cfg.target_width == '0) begin
         size_ok = 1'b1;
      end else if (cfg.exact_size) begin
         size_ok = (active_width == cfg.target_width) &&
                   (active_height == cfg.target_height);
      end else begin
         size_ok = (active_width <= cfg.target_width) &&
                   (active_height <= cfg.target_height);
      end
   end

   always_comb begin
      entry.pass    = type_ok & size_ok & ~interlaced & ~double_scan;
      entry.pref    = (cfg.preferred_refresh != '0) && (refresh_hz == cfg.preferred_refresh);
      entry.last    = last_entry;
      entry.pos     = pos_ff;
      entry.width   = active_width;
      entry.height  = active_height;
      entry.refresh = refresh_hz;
   end

   // position saturates at the cap, restarts after the last item of a list
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (last_entry) begin
            pos_in = '0;
         end else if (pos_ff < PosCap) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

@@ hw/rtl/dmbs_queue.sv @@
module dmbs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dmbs_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output dmbs_pkg::entry_type  head_entry
);

   dmbs_pkg::entry_type              slot_ff [dmbs_pkg::QUEUE_DEPTH];
   logic [dmbs_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [dmbs_pkg::QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [dmbs_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [dmbs_pkg::QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [dmbs_pkg::QUEUE_CNT_W-1:0] count_ff;
   logic [dmbs_pkg::QUEUE_CNT_W-1:0] count_in;

   assign full       = count_ff == dmbs_pkg::QUEUE_CNT_W'(dmbs_pkg::QUEUE_DEPTH);
   assign not_empty  = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/dmbs_back.sv @@
module dmbs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  dmbs_pkg::entry_type              head_entry,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [dmbs_pkg::POS_W-1:0]       rsp_best_position,
   output logic [dmbs_pkg::WIDTH_W-1:0]     rsp_best_width,
   output logic [dmbs_pkg::HEIGHT_W-1:0]    rsp_best_height,
   output logic [dmbs_pkg::REFRESH_W-1:0]   rsp_best_refresh_hz
);

   // stage 1: item with its area
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   dmbs_pkg::entry_type             s1_entry_ff;
   logic [dmbs_pkg::AREA_W-1:0]     s1_area_ff;
   logic [dmbs_pkg::AREA_W-1:0]     s1_area_in;

   // running best of the current list
   logic                            have_ff;
   logic                            have_in;
   logic                            best_pref_ff;
   logic                            best_pref_in;
   logic [dmbs_pkg::AREA_W-1:0]     best_area_ff;
   logic [dmbs_pkg::AREA_W-1:0]     best_area_in;
   logic [dmbs_pkg::REFRESH_W-1:0]  kept_refresh_ff;
   logic [dmbs_pkg::REFRESH_W-1:0]  kept_refresh_in;
   logic [dmbs_pkg::POS_W-1:0]      kept_pos_ff;
   logic [dmbs_pkg::POS_W-1:0]      kept_pos_in;
   logic [dmbs_pkg::WIDTH_W-1:0]    kept_width_ff;
   logic [dmbs_pkg::WIDTH_W-1:0]    kept_width_in;
   logic [dmbs_pkg::HEIGHT_W-1:0]   kept_height_ff;
   logic [dmbs_pkg::HEIGHT_W-1:0]   kept_height_in;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            out_found_ff;
   logic [dmbs_pkg::POS_W-1:0]      out_pos_ff;
   logic [dmbs_pkg::WIDTH_W-1:0]    out_width_ff;
   logic [dmbs_pkg::HEIGHT_W-1:0]   out_height_ff;
   logic [dmbs_pkg::REFRESH_W-1:0]  out_refresh_ff;

   logic out_free;
   logic s1_advance;
   logic s1_fire;
   logic take;
   logic emit;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   // only a last item needs room in the output register
   assign s1_advance = ~s1_valid_ff | ~s1_entry_ff.last | out_free;
   assign pop        = head_valid & s1_advance;
   assign s1_fire    = s1_valid_ff & s1_advance;
   assign emit       = s1_fire & s1_entry_ff.last;

   assign s1_valid_in = pop ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign s1_area_in  = dmbs_pkg::AREA_W'(head_entry.width) *
                        dmbs_pkg::AREA_W'(head_entry.height);

   always_comb begin
      if (!s1_entry_ff.pass) begin
         take = 1'b0;
      end else if (!have_ff) begin
         take = 1'b1;
      end else if (s1_entry_ff.pref != best_pref_ff) begin
         take = s1_entry_ff.pref;
      end else if (s1_area_ff != best_area_ff) begin
         take = s1_area_ff > best_area_ff;
      end else begin
         take = s1_entry_ff.refresh > kept_refresh_ff;
      end
   end

   always_comb begin
      have_in         = have_ff;
      best_pref_in    = best_pref_ff;
      best_area_in    = best_area_ff;
      kept_refresh_in = kept_refresh_ff;
      kept_pos_in     = kept_pos_ff;
      kept_width_in   = kept_width_ff;
      kept_height_in  = kept_height_ff;
      if (s1_fire && take) begin
         have_in         = 1'b1;
         best_pref_in    = s1_entry_ff.pref;
         best_area_in    = s1_area_ff;
         kept_refresh_in = s1_entry_ff.refresh;
         kept_pos_in     = s1_entry_ff.pos;
         kept_width_in   = s1_entry_ff.width;
         kept_height_in  = s1_entry_ff.height;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         have_ff         <= 1'b0;
         best_pref_ff    <= 1'b0;
         best_area_ff    <= '0;
         kept_refresh_ff <= '0;
         kept_pos_ff     <= '0;
         kept_width_ff   <= '0;
         kept_height_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (emit) begin
            // list done: clear for the next scan
            have_ff         <= 1'b0;
            best_pref_ff    <= 1'b0;
            best_area_ff    <= '0;
            kept_refresh_ff <= '0;
            kept_pos_ff     <= '0;
            kept_width_ff   <= '0;
            kept_height_ff  <= '0;
         end else begin
            have_ff         <= have_in;
            best_pref_ff    <= best_pref_in;
            best_area_ff    <= best_area_in;
            kept_refresh_ff <= kept_refresh_in;
            kept_pos_ff     <= kept_pos_in;
            kept_width_ff   <= kept_width_in;
            kept_height_ff  <= kept_height_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_entry_ff <= head_entry;
         s1_area_ff  <= s1_area_in;
      end
      // kept fields are zero whenever nothing has been taken
      if (emit) begin
         out_found_ff   <= have_in;
         out_pos_ff     <= kept_pos_in;
         out_width_ff   <= kept_width_in;
         out_height_ff  <= kept_height_in;
         out_refresh_ff <= kept_refresh_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = out_found_ff;
   assign rsp_best_position   = out_pos_ff;
   assign rsp_best_width      = out_width_ff;
   assign rsp_best_height     = out_height_ff;
   assign rsp_best_refresh_hz = out_refresh_ff;

endmodule

@@ dv/tb_display_mode_best_select_unit.sv @@
`timescale 1ns / 100ps

module tb_display_mode_best_select_unit;

   localparam int MAX_TIMINGS   = 256;
   localparam int POS_CAP       = (MAX_TIMINGS - 1 < 255) ? MAX_TIMINGS - 1 : 255;
   localparam int SETTLE_CYCLES = 4;
   localparam int RAND_LISTS_BUDGET = 16;
   localparam int LONG_LIST_LEN = 262;
   localparam int LONG_LIST_BIG = 258;
   localparam logic [dmbs_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [dmbs_pkg::TYPE_W-1:0]    timing_type;
      logic [dmbs_pkg::WIDTH_W-1:0]   active_width;
      logic [dmbs_pkg::HEIGHT_W-1:0]  active_height;
      logic [dmbs_pkg::REFRESH_W-1:0] refresh_hz;
      logic                           interlaced;
      logic                           double_scan;
      logic                           last_entry;
   } mode_timing_type;

   typedef struct packed {
      logic                           found;
      logic [dmbs_pkg::POS_W-1:0]     position;
      logic [dmbs_pkg::WIDTH_W-1:0]   width;
      logic [dmbs_pkg::HEIGHT_W-1:0]  height;
      logic [dmbs_pkg::REFRESH_W-1:0] refresh;
   } best_mode_type;

   typedef enum logic {ROW_TIMING, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [dmbs_pkg::CSR_IDX_W-1:0]    csr_idx;
      logic [dmbs_pkg::CSR_DATA_W-1:0]   csr_value;
      mode_timing_type                   timing;
      logic                              typed;
      best_mode_type                     typed_best;
   } stim_row_type;

   localparam best_mode_type NO_MODE = '0;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [dmbs_pkg::TYPE_W-1:0]    req_timing_type;
   logic [dmbs_pkg::WIDTH_W-1:0]   req_active_width;
   logic [dmbs_pkg::HEIGHT_W-1:0]  req_active_height;
   logic [dmbs_pkg::REFRESH_W-1:0] req_refresh_hz;
   logic req_interlaced;
   logic req_double_scan;
   logic req_last_entry;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_found;
   logic [dmbs_pkg::POS_W-1:0]     rsp_best_position;
   logic [dmbs_pkg::WIDTH_W-1:0]   rsp_best_width;
   logic [dmbs_pkg::HEIGHT_W-1:0]  rsp_best_height;
   logic [dmbs_pkg::REFRESH_W-1:0] rsp_best_refresh_hz;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [dmbs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dmbs_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dmbs_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   display_mode_best_select_unit #(
      .MAX_TIMINGS(MAX_TIMINGS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_timing_type     (req_timing_type),
      .req_active_width    (req_active_width),
      .req_active_height   (req_active_height),
      .req_refresh_hz      (req_refresh_hz),
      .req_interlaced      (req_interlaced),
      .req_double_scan     (req_double_scan),
      .req_last_entry      (req_last_entry),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_best_position   (rsp_best_position),
      .rsp_best_width      (rsp_best_width),
      .rsp_best_height     (rsp_best_height),
      .rsp_best_refresh_hz (rsp_best_refresh_hz),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // mirror of the block's registers and scan state
   dmbs_pkg::cfg_type              mode_cfg;
   logic [dmbs_pkg::POS_W-1:0]     scan_pos;
   logic                           scan_have;
   logic                           scan_pref;
   logic [dmbs_pkg::AREA_W-1:0]    scan_area;
   logic [dmbs_pkg::REFRESH_W-1:0] scan_refresh;
   logic [dmbs_pkg::POS_W-1:0]     scan_at;
   logic [dmbs_pkg::WIDTH_W-1:0]   scan_w;
   logic [dmbs_pkg::HEIGHT_W-1:0]  scan_h;

   best_mode_type pending_best[$];
   int mismatch_count;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb_display_mode_best_select_unit: FAIL");
      $finish;
   end

   function automatic void clear_scan();
      scan_pos     = '0;
      scan_have    = 1'b0;
      scan_pref    = 1'b0;
      scan_area    = '0;
      scan_refresh = '0;
      scan_at      = '0;
      scan_w       = '0;
      scan_h       = '0;
   endfunction

   // filter one timing, update the running winner, report on the list's last timing
   function automatic void rank_timing(input mode_timing_type t, output logic done,
                                       output best_mode_type res);
      logic pass;
      logic pref;
      logic take;
      logic [dmbs_pkg::AREA_W-1:0] area;
      pass = (t.timing_type & mode_cfg.required_type_bits) == mode_cfg.required_type_bits;
      if (mode_cfg.target_width != 0) begin
         if (mode_cfg.exact_size ?
             (t.active_width != mode_cfg.target_width ||
              t.active_height != mode_cfg.target_height) :
             (t.active_width > mode_cfg.target_width ||
              t.active_height > mode_cfg.target_height))
            pass = 1'b0;
      end
      if (t.interlaced || t.double_scan)
         pass = 1'b0;
      if (pass) begin
         area = dmbs_pkg::AREA_W'(t.active_width) * dmbs_pkg::AREA_W'(t.active_height);
         pref = mode_cfg.preferred_refresh != 0 && t.refresh_hz == mode_cfg.preferred_refresh;
         if (!scan_have)
            take = 1'b1;
         else if (pref != scan_pref)
            take = pref;
         else if (area != scan_area)
            take = area > scan_area;
         else
            take = t.refresh_hz > scan_refresh;   // full tie keeps the earlier timing
         if (take) begin
            scan_have    = 1'b1;
            scan_pref    = pref;
            scan_area    = area;
            scan_refresh = t.refresh_hz;
            scan_at      = scan_pos;
            scan_w       = t.active_width;
            scan_h       = t.active_height;
         end
      end
      if (scan_pos < POS_CAP)
         scan_pos++;
      done = t.last_entry;
      res  = NO_MODE;
      if (t.last_entry) begin
         if (scan_have)
            res = {1'b1, scan_at, scan_w, scan_h, scan_refresh};
         clear_scan();
      end
   endfunction

   function automatic stim_row_type mode_row(input logic [dmbs_pkg::TYPE_W-1:0] ty,
                                             input logic [dmbs_pkg::WIDTH_W-1:0] w,
                                             input logic [dmbs_pkg::HEIGHT_W-1:0] h,
                                             input logic [dmbs_pkg::REFRESH_W-1:0] rf,
                                             input logic il, input logic ds,
                                             input logic lst, input logic typed,
                                             input best_mode_type best);
      stim_row_type r;
      r = '0;
      r.kind       = ROW_TIMING;
      r.timing     = {ty, w, h, rf, il, ds, lst};
      r.typed      = typed;
      r.typed_best = best;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [dmbs_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [dmbs_pkg::CSR_DATA_W-1:0] value);
      stim_row_type r;
      r = '0;
      r.kind      = ROW_CSR;
      r.csr_idx   = idx;
      r.csr_value = value;
      return r;
   endfunction

   // mostly timings shaped to get past the filters, the rest fully random
   function automatic mode_timing_type random_timing(input logic lst);
      mode_timing_type t;
      t.timing_type   = dmbs_pkg::TYPE_W'($urandom);
      t.active_width  = dmbs_pkg::WIDTH_W'($urandom);
      t.active_height = dmbs_pkg::HEIGHT_W'($urandom);
      t.refresh_hz    = dmbs_pkg::REFRESH_W'($urandom);
      t.interlaced    = 1'($urandom);
      t.double_scan   = 1'($urandom);
      if ($urandom_range(99) >= 20) begin
         t.timing_type = t.timing_type | mode_cfg.required_type_bits;
         t.interlaced  = $urandom_range(9) == 0;
         t.double_scan = $urandom_range(9) == 0;
         case ($urandom_range(3))
            0: begin
               t.active_width  = 640;
               t.active_height = 480;
            end
            1: begin
               t.active_width  = 1280;
               t.active_height = 720;
            end
            2: begin
               t.active_width  = 720;   // same area as 1280x720
               t.active_height = 1280;
            end
            default: begin
               t.active_width  = dmbs_pkg::WIDTH_W'($urandom_range(4096, 1));
               t.active_height = dmbs_pkg::HEIGHT_W'($urandom_range(4096, 1));
            end
         endcase
         if (mode_cfg.target_width != 0) begin
            if (mode_cfg.exact_size || $urandom_range(3) == 0) begin
               t.active_width  = mode_cfg.target_width;
               t.active_height = mode_cfg.target_height;
            end else begin
               t.active_width  = dmbs_pkg::WIDTH_W'($urandom_range(mode_cfg.target_width));
               t.active_height = dmbs_pkg::HEIGHT_W'($urandom_range(mode_cfg.target_height));
            end
         end
         case ($urandom_range(3))
            0: t.refresh_hz = mode_cfg.preferred_refresh;
            1: t.refresh_hz = 60;
            2: t.refresh_hz = 75;
            default: t.refresh_hz = dmbs_pkg::REFRESH_W'($urandom);
         endcase
      end
      t.last_entry = lst;
      return t;
   endfunction

   // called and returns at a falling edge
   task automatic write_csr(input logic [dmbs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dmbs_pkg::CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         dmbs_pkg::CSR_REQUIRED_TYPE:
            mode_cfg.required_type_bits = value[dmbs_pkg::TYPE_W-1:0];
         dmbs_pkg::CSR_TARGET_WIDTH:
            mode_cfg.target_width       = value[dmbs_pkg::WIDTH_W-1:0];
         dmbs_pkg::CSR_TARGET_HEIGHT:
            mode_cfg.target_height      = value[dmbs_pkg::HEIGHT_W-1:0];
         dmbs_pkg::CSR_EXACT_SIZE:
            mode_cfg.exact_size         = value[0];
         dmbs_pkg::CSR_PREF_REFRESH:
            mode_cfg.preferred_refresh  = value[dmbs_pkg::REFRESH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic send_timing(input mode_timing_type t, input logic typed,
                              input best_mode_type typed_best);
      logic done;
      best_mode_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_timing_type   = t.timing_type;
      req_active_width  = t.active_width;
      req_active_height = t.active_height;
      req_refresh_hz    = t.refresh_hz;
      req_interlaced    = t.interlaced;
      req_double_scan   = t.double_scan;
      req_last_entry    = t.last_entry;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      rank_timing(t, done, res);
      if (done)
         pending_best.push_back(typed ? typed_best : res);
      @(negedge clock);
   endtask

   // hold the sender until every pending result is out, then let the pipe settle
   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_best.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input best_mode_type want,
                                  input best_mode_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: exp found=%0d pos=%0d %0dx%0d@%0d got found=%0d pos=%0d %0dx%0d@%0d",
                  $realtime, what, want.found, want.position, want.width, want.height,
                  want.refresh, got.found, got.position, got.width, got.height, got.refresh);
   endtask

   always @(negedge clock)
      rsp_stall = !reset && ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      best_mode_type got;
      got = {rsp_found, rsp_best_position, rsp_best_width, rsp_best_height,
             rsp_best_refresh_hz};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_best.size() == 0)
            report_mismatch("unexpected item", NO_MODE, got);
         else if (got != pending_best[0]) begin
            report_mismatch("mismatch", pending_best[0], got);
            void'(pending_best.pop_front());
         end else
            void'(pending_best.pop_front());
      end
   end

   initial begin
      stim_row_type rows[$];
      mode_timing_type t;
      logic [dmbs_pkg::CSR_DATA_W-1:0] v;
      int sent;
      int len;

      reset          = 1'b1;
      req_valid      = 1'b0;
      {req_timing_type, req_active_width, req_active_height, req_refresh_hz} = '0;
      {req_interlaced, req_double_scan, req_last_entry} = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mode_cfg       = '0;
      mismatch_count = 0;
      send_idle_pct  = 15;
      recv_stall_pct = 67;
      clear_scan();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rows = '{
         // registers at reset value: type and size filters pass everything, interlaced and double-scan still fail
         mode_row(8'h00, 0, 0, 0, 0, 0, 1, 1, {1'b1, 8'd0, 16'd0, 16'd0, 10'd0}),
         mode_row(8'hFF, 640, 480, 60, 1, 0, 1, 1, NO_MODE),
         mode_row(8'hFF, 640, 480, 60, 0, 1, 1, 1, NO_MODE),
         // area tie decided by refresh, then full tie keeps the first
         mode_row(8'h01, 100, 100, 60, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h02, 200, 100, 30, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h04, 200, 100, 75, 0, 0, 1, 0, NO_MODE),
         mode_row(8'h00, 50, 50, 60, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h00, 50, 50, 60, 0, 0, 1, 0, NO_MODE),
         csr_row(dmbs_pkg::CSR_REQUIRED_TYPE, 32'h41),
         csr_row(dmbs_pkg::CSR_TARGET_WIDTH, 1920),
         csr_row(dmbs_pkg::CSR_TARGET_HEIGHT, 1080),
         csr_row(dmbs_pkg::CSR_EXACT_SIZE, 1),
         csr_row(dmbs_pkg::CSR_PREF_REFRESH, 60),
         mode_row(8'h40, 1920, 1080, 60, 0, 0, 1, 1, NO_MODE),
         mode_row(8'h41, 1920, 1080, 75, 0, 0, 0, 0, NO_MODE),
         mode_row(8'hFF, 1920, 1080, 60, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h41, 1280, 720, 60, 0, 0, 1, 0, NO_MODE),
         csr_row(dmbs_pkg::CSR_EXACT_SIZE, 0),
         csr_row(dmbs_pkg::CSR_PREF_REFRESH, 0),
         mode_row(8'h41, 1920, 1080, 30, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h41, 1280, 720, 144, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h41, 2560, 1440, 60, 0, 0, 1, 0, NO_MODE),
         mode_row(8'h41, 1921, 100, 60, 0, 0, 1, 1, NO_MODE),
         csr_row(dmbs_pkg::CSR_REQUIRED_TYPE, 32'hFF),
         csr_row(dmbs_pkg::CSR_TARGET_WIDTH, 32'hFFFF),
         csr_row(dmbs_pkg::CSR_TARGET_HEIGHT, 32'hFFFF),
         csr_row(dmbs_pkg::CSR_EXACT_SIZE, 1),
         csr_row(dmbs_pkg::CSR_PREF_REFRESH, 32'h3FF),
         mode_row(8'hFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 0, 0, 1, 1,
                  {1'b1, 8'd0, 16'hFFFF, 16'hFFFF, 10'h3FF}),
         // size filter off; preferred refresh beats a bigger area
         csr_row(dmbs_pkg::CSR_TARGET_WIDTH, 0),
         csr_row(dmbs_pkg::CSR_REQUIRED_TYPE, 0),
         csr_row(CSR_SPARE, 32'hFFFF_FFFF),
         mode_row(8'h00, 640, 480, 10'h3FF, 0, 0, 0, 0, NO_MODE),
         mode_row(8'h00, 4000, 4000, 60, 0, 0, 1, 0, NO_MODE)
      };
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_drain();
            write_csr(rows[i].csr_idx, rows[i].csr_value);
         end else
            send_timing(rows[i].timing, rows[i].typed, rows[i].typed_best);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 67 : 0;
         recv_stall_pct = (phase == 0) ? 67 : (phase == 1) ? 15 : 0;
         for (int sub = 0; sub < 3; sub++) begin
            wait_drain();
            case ($urandom_range(3))
               0: v = 0;
               1: v = 32'hFF;
               default: v = $urandom_range(255);
            endcase
            write_csr(dmbs_pkg::CSR_REQUIRED_TYPE, v);
            case ($urandom_range(3))
               0: v = 0;
               1: v = 32'hFFFF;
               2: v = 1920;
               default: v = $urandom_range(65535);
            endcase
            write_csr(dmbs_pkg::CSR_TARGET_WIDTH, v);
            case ($urandom_range(3))
               0: v = 0;
               1: v = 32'hFFFF;
               2: v = 1080;
               default: v = $urandom_range(65535);
            endcase
            write_csr(dmbs_pkg::CSR_TARGET_HEIGHT, v);
            write_csr(dmbs_pkg::CSR_EXACT_SIZE, $urandom_range(1));
            case ($urandom_range(3))
               0: v = 0;
               1: v = 32'h3FF;
               2: v = 60;
               default: v = $urandom_range(1023);
            endcase
            write_csr(dmbs_pkg::CSR_PREF_REFRESH, v);
            sent = 0;
            while (sent < RAND_LISTS_BUDGET) begin
               len = $urandom_range(8, 1);
               for (int k = 0; k < len; k++)
                  send_timing(random_timing(k == len - 1), 1'b0, NO_MODE);
               sent += len;
               if ($urandom_range(19) == 0)
                  wait_drain();
            end
         end
      end

      // one list past the position counter's ceiling, winner placed after it
      wait_drain();
      write_csr(dmbs_pkg::CSR_REQUIRED_TYPE, 0);
      write_csr(dmbs_pkg::CSR_TARGET_WIDTH, 0);
      write_csr(dmbs_pkg::CSR_PREF_REFRESH, 0);
      for (int k = 0; k < LONG_LIST_LEN; k++) begin
         t = random_timing(k == LONG_LIST_LEN - 1);
         if (k == LONG_LIST_BIG) begin
            t.active_width  = '1;
            t.active_height = '1;
            t.refresh_hz    = '1;
            t.interlaced    = 1'b0;
            t.double_scan   = 1'b0;
         end
         send_timing(t, 1'b0, NO_MODE);
      end

      wait_drain();
      if (mismatch_count == 0)
         $display("tb_display_mode_best_select_unit: PASS");
      else
         $display("tb_display_mode_best_select_unit: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/dmbs_pkg.sv
hw/rtl/dmbs_csr.sv
hw/rtl/dmbs_front.sv
hw/rtl/dmbs_queue.sv
hw/rtl/dmbs_back.sv
hw/rtl/display_mode_best_select_unit.sv
dv/tb_display_mode_best_select_unit.sv
